[src/ffrd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffrd_pkg
// Shared types and constants of the flag-framed receiver and decoder.
// ----------------------------------------------------------------------------
package ffrd_pkg;

  // bearing and heading width
  localparam int BEAR_W = 15;
  // scaled bearing difference fed to the divider (15 x 15 bit product)
  localparam int NUM_W  = 2 * BEAR_W;
  // divider step counter width
  localparam int DCNT_W = $clog2(NUM_W + 1);

  // apb register window
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // one full turn in 1/64 degree units
  localparam logic [BEAR_W-1:0] FULL_TURN = 15'd23040;
  // largest drop from the previous raw bearing that is still believed
  localparam logic [BEAR_W:0]   GLITCH_DROP = 16'd15;
  // expected payload sizes
  localparam logic [7:0] SONAR_SIZE   = 8'd5;
  localparam logic [7:0] COMPASS_SIZE = 8'd2;

  // register indexes
  localparam logic [2:0] REG_OPEN_BYTE   = 3'd0;
  localparam logic [2:0] REG_CLOSE_BYTE  = 3'd1;
  localparam logic [2:0] REG_SONAR_OP    = 3'd2;
  localparam logic [2:0] REG_COMPASS_OP  = 3'd3;
  localparam logic [2:0] REG_COMPASS_LO  = 3'd4;
  localparam logic [2:0] REG_COMPASS_HI  = 3'd5;
  localparam logic [2:0] REG_MAP_EN      = 3'd6;

  // result event codes
  typedef enum logic [3:0] {
    EV_ACK          = 4'd0,
    EV_SONAR        = 4'd1,
    EV_COMPASS      = 4'd2,
    EV_STRAY        = 4'd3,
    EV_EARLY_START  = 4'd4,
    EV_OVERFLOW     = 4'd5,
    EV_BAD_LENGTH   = 4'd6,
    EV_BAD_SONAR    = 4'd7,
    EV_BAD_COMPASS  = 4'd8,
    EV_UNKNOWN_OP   = 4'd9
  } evt_t;

endpackage

[src/ffrd_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffrd_div
// Restoring divider, one quotient bit per cycle, for the heading scale.
// ----------------------------------------------------------------------------
module ffrd_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ffrd_pkg::NUM_W-1:0]   num,
  input  logic [ffrd_pkg::BEAR_W-1:0]  den,
  output logic                         done,
  output logic [ffrd_pkg::BEAR_W-1:0]  quo
);
  import ffrd_pkg::*;

  logic [NUM_W-1:0]  num_r;
  logic [BEAR_W-1:0] den_r;
  logic [BEAR_W-1:0] rem_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [BEAR_W:0]   rem_sh;
  logic [BEAR_W:0]   rem_sub;
  logic              q_bit;

  // trial subtract of the shifted remainder
  always_comb begin
    rem_sh  = {rem_r, num_r[NUM_W-1]};
    q_bit   = (rem_sh >= {1'b0, den_r});
    rem_sub = rem_sh - {1'b0, den_r};
  end

  // step sequencer, quotient bits shift into the numerator register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(NUM_W);
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= q_bit ? rem_sub[BEAR_W-1:0] : rem_sh[BEAR_W-1:0];
        num_r <= {num_r[NUM_W-2:0], q_bit};
        cnt_r <= cnt_r - DCNT_W'(1);
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient never exceeds a full turn
  assign done = done_r;
  assign quo  = num_r[BEAR_W-1:0];

endmodule

[src/flag_frame_receiver_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flag_frame_receiver_decoder
// Flag-framed serial byte receiver: buffers a frame in a byte memory and
// decodes acknowledge, sonar and compass frames and framing faults.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  in_      | input     | in_valid / in_stall    | in_rx_byte
//  out_     | output    | out_valid / out_stall  | event, sonar bytes, compass
//  apb      | input     | psel/penable/pready    | paddr, pwdata, prdata
//
//  A data byte, start flag or stray byte is handled as it is accepted, in the idle state.
//  A stop flag that closes a non-empty frame has its header and payload read
//  back from the frame memory (one read port) and checked; a mapped compass
//  frame with a nonempty range then passes through clamp, multiply, divider
//  start and the bit-serial divider, an empty or inverted one only the clamp.
//  No new byte is taken while a frame is decoded or a result waits behind a
//  stalled output; reset needs no clearing pass.
// ----------------------------------------------------------------------------
module flag_frame_receiver_decoder #(
  parameter int FRAME_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input bytes
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_rx_byte,
  // results
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [3:0]                    out_event_res,
  output logic [7:0]                    out_sonar_angle,
  output logic [7:0]                    out_sonar_dist_a,
  output logic [7:0]                    out_sonar_dist_b,
  output logic [7:0]                    out_sonar_dist_c,
  output logic [7:0]                    out_sonar_dist_d,
  output logic [ffrd_pkg::BEAR_W-1:0]   out_compass_bearing,
  output logic [ffrd_pkg::BEAR_W-1:0]   out_compass_degrees,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ffrd_pkg::ADDR_W-1:0]   paddr,
  input  logic [ffrd_pkg::DATA_W-1:0]   pwdata,
  output logic [ffrd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import ffrd_pkg::*;

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int LW = $clog2(FRAME_BYTES + 1);
  localparam int HDR_BYTES = 7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_MAP,
    S_MUL,
    S_DIVGO,
    S_DIV
  } state_t;

  // configuration registers
  logic [7:0]        open_byte_r;
  logic [7:0]        close_byte_r;
  logic [7:0]        sonar_op_r;
  logic [7:0]        compass_op_r;
  logic [BEAR_W-1:0] compass_lo_r;
  logic [BEAR_W-1:0] compass_hi_r;
  logic              map_en_r;

  // framing state
  state_t            state_r;
  logic              in_frame_r;
  logic [LW-1:0]     len_r;
  logic [LW-1:0]     cap_len_r;
  logic [BEAR_W-1:0] prev_r;
  logic [2:0]        rd_cnt_r;
  logic [7:0]        hdr_r [HDR_BYTES];
  logic [BEAR_W-1:0] val_r;
  logic [BEAR_W-1:0] diff_r;
  logic [BEAR_W-1:0] den_r;
  logic [NUM_W-1:0]  prod_r;

  // frame memory
  logic [7:0]        mem [FRAME_BYTES];
  logic [7:0]        rd_data_r;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [AW-1:0]     mem_ra;

  // output register
  logic              out_valid_r;
  evt_t              out_ev_r;
  logic [7:0]        out_angle_r;
  logic [7:0]        out_da_r;
  logic [7:0]        out_db_r;
  logic [7:0]        out_dc_r;
  logic [7:0]        out_dd_r;
  logic [BEAR_W-1:0] out_bear_r;
  logic [BEAR_W-1:0] out_deg_r;

  // result built this cycle
  logic              res_fire;
  evt_t              res_ev;
  logic [7:0]        res_angle;
  logic [7:0]        res_da;
  logic [7:0]        res_db;
  logic [7:0]        res_dc;
  logic [7:0]        res_dd;
  logic [BEAR_W-1:0] res_bear;
  logic [BEAR_W-1:0] res_deg;

  logic              in_acc;
  logic              out_take;
  logic              cfg_wr;
  logic [2:0]        cfg_idx;

  // compass working values
  logic [BEAR_W:0]   raw_sum;
  logic [BEAR_W-1:0] raw;
  logic [BEAR_W-1:0] filt;
  logic [BEAR_W-1:0] clamp_lo;
  logic [BEAR_W-1:0] clamp;
  logic [8:0]        len_want;

  logic              div_start;
  logic              div_done;
  logic [BEAR_W-1:0] div_quo;

  // handshakes
  assign out_take = out_valid_r & ~out_stall;
  assign in_stall = ~((state_r == S_IDLE) & (~out_valid_r | ~out_stall));
  assign in_acc   = in_valid & ~in_stall;

  // apb register file
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_byte_r  <= 8'd254;
      close_byte_r <= 8'd255;
      sonar_op_r   <= 8'd1;
      compass_op_r <= 8'd2;
      compass_lo_r <= 15'd0;
      compass_hi_r <= 15'd3600;
      map_en_r     <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_OPEN_BYTE:  open_byte_r  <= pwdata[7:0];
        REG_CLOSE_BYTE: close_byte_r <= pwdata[7:0];
        REG_SONAR_OP:   sonar_op_r   <= pwdata[7:0];
        REG_COMPASS_OP: compass_op_r <= pwdata[7:0];
        REG_COMPASS_LO: compass_lo_r <= pwdata[BEAR_W-1:0];
        REG_COMPASS_HI: compass_hi_r <= pwdata[BEAR_W-1:0];
        REG_MAP_EN:     map_en_r     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_OPEN_BYTE:  prdata = DATA_W'(open_byte_r);
      REG_CLOSE_BYTE: prdata = DATA_W'(close_byte_r);
      REG_SONAR_OP:   prdata = DATA_W'(sonar_op_r);
      REG_COMPASS_OP: prdata = DATA_W'(compass_op_r);
      REG_COMPASS_LO: prdata = DATA_W'(compass_lo_r);
      REG_COMPASS_HI: prdata = DATA_W'(compass_hi_r);
      REG_MAP_EN:     prdata = DATA_W'(map_en_r);
      default:        prdata = '0;
    endcase
  end

  // frame memory write on a data byte that fits
  always_comb begin
    mem_we = in_acc & in_frame_r & (in_rx_byte != open_byte_r)
           & (in_rx_byte != close_byte_r) & (len_r < LW'(FRAME_BYTES));
    mem_wa = len_r[AW-1:0];
    mem_ra = (rd_cnt_r < 3'(HDR_BYTES)) ? AW'(rd_cnt_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= in_rx_byte;
    end
    rd_data_r <= mem[mem_ra];
  end

  // compass raw value, glitch filter and clamp
  always_comb begin
    raw_sum  = {1'b0, hdr_r[3], 7'b0} + {8'b0, hdr_r[2]};
    raw      = raw_sum[BEAR_W] ? {BEAR_W{1'b1}} : raw_sum[BEAR_W-1:0];
    filt     = ({1'b0, prev_r} > ({1'b0, raw} + GLITCH_DROP)) ? prev_r : raw;
    clamp_lo = (val_r < compass_lo_r) ? compass_lo_r : val_r;
    clamp    = (clamp_lo > compass_hi_r) ? compass_hi_r : clamp_lo;
    len_want = {1'b0, hdr_r[0]} + 9'd2;
  end

  // result selection
  always_comb begin
    res_fire  = 1'b0;
    res_ev    = EV_ACK;
    res_angle = '0;
    res_da    = '0;
    res_db    = '0;
    res_dc    = '0;
    res_dd    = '0;
    res_bear  = '0;
    res_deg   = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!in_frame_r) begin
            if (in_rx_byte != open_byte_r) begin
              res_fire = 1'b1;
              res_ev   = EV_STRAY;
            end
          end else if (in_rx_byte == open_byte_r) begin
            res_fire = 1'b1;
            res_ev   = EV_EARLY_START;
          end else if (in_rx_byte == close_byte_r) begin
            if (len_r == '0) begin
              res_fire = 1'b1;
              res_ev   = EV_ACK;
            end
          end else if (len_r >= LW'(FRAME_BYTES)) begin
            res_fire = 1'b1;
            res_ev   = EV_OVERFLOW;
          end
        end
      end
      S_CHECK: begin
        if (len_want != 9'(cap_len_r)) begin
          res_fire = 1'b1;
          res_ev   = EV_BAD_LENGTH;
        end else if (hdr_r[1] == sonar_op_r) begin
          res_fire = 1'b1;
          if (hdr_r[0] != SONAR_SIZE) begin
            res_ev = EV_BAD_SONAR;
          end else begin
            res_ev    = EV_SONAR;
            res_angle = hdr_r[6];
            res_da    = hdr_r[2];
            res_db    = hdr_r[3];
            res_dc    = hdr_r[4];
            res_dd    = hdr_r[5];
          end
        end else if (hdr_r[1] == compass_op_r) begin
          if (hdr_r[0] != COMPASS_SIZE) begin
            res_fire = 1'b1;
            res_ev   = EV_BAD_COMPASS;
          end else if (!map_en_r) begin
            res_fire = 1'b1;
            res_ev   = EV_COMPASS;
            res_bear = filt;
          end
        end else begin
          res_fire = 1'b1;
          res_ev   = EV_UNKNOWN_OP;
        end
      end
      S_MAP: begin
        if (compass_hi_r == compass_lo_r) begin
          res_fire = 1'b1;
          res_ev   = EV_COMPASS;
          res_bear = clamp;
        end else if (compass_hi_r < compass_lo_r) begin
          res_fire = 1'b1;
          res_ev   = EV_COMPASS;
          res_bear = compass_hi_r;
          res_deg  = FULL_TURN;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_fire = 1'b1;
          res_ev   = EV_COMPASS;
          res_bear = val_r;
          res_deg  = div_quo;
        end
      end
      default: ;
    endcase
  end

  // heading scale divider
  assign div_start = (state_r == S_DIVGO);

  ffrd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // frame sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_frame_r  <= 1'b0;
      len_r       <= '0;
      prev_r      <= '0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_take) begin
        out_valid_r <= 1'b0;
      end
      if (res_fire) begin
        out_valid_r <= 1'b1;
        out_ev_r    <= res_ev;
        out_angle_r <= res_angle;
        out_da_r    <= res_da;
        out_db_r    <= res_db;
        out_dc_r    <= res_dc;
        out_dd_r    <= res_dd;
        out_bear_r  <= res_bear;
        out_deg_r   <= res_deg;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (!in_frame_r) begin
              if (in_rx_byte == open_byte_r) begin
                in_frame_r <= 1'b1;
                len_r      <= '0;
              end
            end else if (in_rx_byte == open_byte_r) begin
              len_r <= '0;
            end else if (in_rx_byte == close_byte_r) begin
              in_frame_r <= 1'b0;
              len_r      <= '0;
              cap_len_r  <= len_r;
              if (len_r != '0) begin
                rd_cnt_r <= '0;
                state_r  <= S_READ;
              end
            end else if (len_r >= LW'(FRAME_BYTES)) begin
              in_frame_r <= 1'b0;
              len_r      <= '0;
            end else begin
              len_r <= len_r + LW'(1);
            end
          end
        end
        S_READ: begin
          // address k is issued while byte k-1 returns
          if (rd_cnt_r != '0) begin
            hdr_r[rd_cnt_r - 3'd1] <= rd_data_r;
          end
          rd_cnt_r <= rd_cnt_r + 3'd1;
          if (rd_cnt_r == 3'(HDR_BYTES)) begin
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (res_fire) begin
            state_r <= S_IDLE;
          end
          if ((len_want == 9'(cap_len_r)) && (hdr_r[1] != sonar_op_r)
              && (hdr_r[1] == compass_op_r) && (hdr_r[0] == COMPASS_SIZE)) begin
            prev_r <= raw;
            val_r  <= filt;
            if (map_en_r) begin
              state_r <= S_MAP;
            end
          end
        end
        S_MAP: begin
          val_r  <= clamp;
          diff_r <= clamp - compass_lo_r;
          den_r  <= compass_hi_r - compass_lo_r;
          state_r <= res_fire ? S_IDLE : S_MUL;
        end
        S_MUL: begin
          prod_r  <= NUM_W'(diff_r) * NUM_W'(FULL_TURN);
          state_r <= S_DIVGO;
        end
        S_DIVGO: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_event_res       = out_ev_r;
  assign out_sonar_angle     = out_angle_r;
  assign out_sonar_dist_a    = out_da_r;
  assign out_sonar_dist_b    = out_db_r;
  assign out_sonar_dist_c    = out_dc_r;
  assign out_sonar_dist_d    = out_dd_r;
  assign out_compass_bearing = out_bear_r;
  assign out_compass_degrees = out_deg_r;

endmodule
